// ===== hdl/bfha_pkg.sv =====
`timescale 1ns / 1ps
package bfha_pkg;
    localparam int FUNC_W = 1;
    localparam int FIELD_W = 12;
    localparam int STATUS_W = 2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNKNOWN = 2'd3
    } status_t;
endpackage

// ===== hdl/bfha_if.sv =====
`timescale 1ns / 1ps
interface bfha_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [11:0] req_size;
    logic [11:0] data_offset;
    modport source (output valid, func, req_size, data_offset, input ready);
    modport sink   (input valid, func, req_size, data_offset, output ready);
endinterface

interface bfha_rsp_if;
    logic        valid;
    logic        ready;
    logic [11:0] alloc_offset;
    logic [1:0]  status;
    modport source (output valid, alloc_offset, status, input ready);
    modport sink   (input valid, alloc_offset, status, output ready);
endinterface

// ===== hdl/bfha_ram.sv =====
`timescale 1ns / 1ps
module bfha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write, one registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/best_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// Best-fit allocator over an address-ordered segment table held in one RAM
// (offset, size, used per entry). One request is handled at a time: ready is
// low until the response is taken. An allocate scans all segments and, when it
// succeeds, moves the tail of the table up by one entry for the split. A free
// scans for the offset, marks the segment free and may move the tail down once
// or twice; a free that merges on both sides near the head of a full table is
// the slowest case. A free of offset 0 skips the scan. Every step uses one RAM
// read and one write port. No clearing pass.
module best_fit_heap_allocator #(
    parameter int ARENA_BYTES  = 4096,
    parameter int HEADER_BYTES = 16,
    parameter int MAX_SEGMENTS = 32
) (
    input  logic clk,
    input  logic rst_n,
    bfha_req_if.sink   req,
    bfha_rsp_if.source rsp
);
    import bfha_pkg::*;

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int EW = 2 * FIELD_W + 1;
    localparam logic [FIELD_W-1:0] HDR = FIELD_W'(HEADER_BYTES);
    localparam logic [FIELD_W-1:0] SIZE0 = FIELD_W'(ARENA_BYTES - HEADER_BYTES);
    localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_DECIDE, S_SHUP_RD, S_SHUP_WR,
        S_SPLIT, S_FREE_NX, S_FREE_NXCHK, S_FREE_PV, S_FREE_PVCHK,
        S_SHDN_RD, S_SHDN_WR, S_RESP
    } state_t;

    state_t state_reg;
    logic   func_reg;
    logic [FIELD_W-1:0] req_reg, doff_reg;
    logic [CW-1:0] cnt_reg;
    logic [IW-1:0] idx_reg, best_reg, tgt_reg, rmv_reg;
    logic [FIELD_W:0] best_sz_reg;
    logic found_reg, pv_phase_reg;
    logic [FIELD_W-1:0] cur_off_reg, cur_sz_reg;
    logic [FIELD_W-1:0] out_off_reg;
    status_t status_reg;
    logic init_reg;

    // table RAM
    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;

    bfha_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_tbl (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [FIELD_W-1:0] r_off, r_sz;
    logic               r_used;
    assign r_off  = rdata[2*FIELD_W:FIELD_W+1];
    assign r_sz   = rdata[FIELD_W:1];
    assign r_used = rdata[0];

    // shared adder
    logic [FIELD_W:0] need;
    assign need = {1'b0, req_reg} + {1'b0, HDR};

    logic [FIELD_W-1:0] merged;
    assign merged = cur_sz_reg + r_sz + HDR;

    // RAM ports
    always_comb
    begin
        we = 1'b0;
        waddr = idx_reg;
        wdata = rdata;
        raddr = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                we = init_reg;
                waddr = '0;
                wdata = {{FIELD_W{1'b0}}, SIZE0, 1'b0};
                raddr = '0;
            end
            S_SHUP_RD: raddr = idx_reg - IW'(1);
            S_SHUP_WR:
            begin
                we = 1'b1;
                waddr = idx_reg;
            end
            S_SPLIT:
            begin
                we = 1'b1;
                waddr = pv_phase_reg ? best_reg : best_reg + IW'(1);
                wdata = pv_phase_reg ? {cur_off_reg, cur_sz_reg, 1'b0}
                                     : {out_off_reg - HDR, req_reg, 1'b1};
            end
            S_FREE_NX:    raddr = tgt_reg + IW'(1);
            S_FREE_PV:    raddr = tgt_reg - IW'(1);
            // target written free, absorbing a free next entry
            S_FREE_NXCHK:
            begin
                we = 1'b1;
                waddr = tgt_reg;
                wdata = {cur_off_reg,
                         (!pv_phase_reg && !r_used) ? merged : cur_sz_reg, 1'b0};
            end
            // a free previous entry absorbs the target
            S_FREE_PVCHK:
            begin
                we = !r_used;
                waddr = tgt_reg - IW'(1);
                wdata = {r_off, merged, 1'b0};
            end
            S_SHDN_RD: raddr = idx_reg + IW'(1);
            S_SHDN_WR:
            begin
                we = 1'b1;
                waddr = idx_reg;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= CW'(1);
            init_reg <= 1'b1;
            pv_phase_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    init_reg <= 1'b0;
                    if (req.valid && !init_reg)
                    begin
                        func_reg <= req.func;
                        req_reg <= req.req_size;
                        doff_reg <= req.data_offset;
                        idx_reg <= '0;
                        found_reg <= 1'b0;
                        pv_phase_reg <= 1'b0;
                        best_sz_reg <= (FIELD_W+1)'(ARENA_BYTES) + 1'b1;
                        out_off_reg <= '0;
                        status_reg <= ST_OK;
                        if (req.func == FUNC_FREE && req.data_offset == '0)
                            state_reg <= S_RESP;
                        else
                            state_reg <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: state_reg <= S_SCAN_CHK;
                S_SCAN_CHK:
                begin
                    if (func_reg == FUNC_ALLOC)
                    begin
                        if (!r_used && {1'b0, r_sz} >= need &&
                            {1'b0, r_sz} <= best_sz_reg)
                        begin
                            best_reg <= idx_reg;
                            best_sz_reg <= {1'b0, r_sz};
                            cur_off_reg <= r_off;
                            cur_sz_reg <= r_sz;
                            found_reg <= 1'b1;
                        end
                    end
                    else if (!found_reg && r_off + HDR == doff_reg)
                    begin
                        found_reg <= 1'b1;
                        tgt_reg <= idx_reg;
                        cur_off_reg <= r_off;
                        cur_sz_reg <= r_sz;
                    end
                    if (CW'(idx_reg) + CW'(1) == cnt_reg)
                        state_reg <= S_DECIDE;
                    else
                    begin
                        idx_reg <= idx_reg + IW'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_DECIDE:
                begin
                    if (func_reg == FUNC_ALLOC)
                    begin
                        if (!found_reg)
                        begin
                            status_reg <= ST_NO_FIT;
                            state_reg <= S_RESP;
                        end
                        else if (cnt_reg >= MAXC)
                        begin
                            status_reg <= ST_FULL;
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            cur_sz_reg <= cur_sz_reg - need[FIELD_W-1:0];
                            out_off_reg <= cur_off_reg + HDR
                                           + (cur_sz_reg - need[FIELD_W-1:0]) + HDR;
                            idx_reg <= cnt_reg[IW-1:0];
                            if (CW'(best_reg) + CW'(1) == cnt_reg)
                                state_reg <= S_SPLIT;
                            else
                                state_reg <= S_SHUP_RD;
                        end
                    end
                    else if (!found_reg)
                    begin
                        status_reg <= ST_UNKNOWN;
                        state_reg <= S_RESP;
                    end
                    else if (CW'(tgt_reg) + CW'(1) < cnt_reg)
                        state_reg <= S_FREE_NX;
                    else
                    begin
                        // no next entry: mark the target free, then check the previous entry
                        pv_phase_reg <= 1'b1;
                        state_reg <= S_FREE_NXCHK;
                    end
                end
                // move entries up from count-1 down to best+1
                S_SHUP_RD: state_reg <= S_SHUP_WR;
                S_SHUP_WR:
                begin
                    if (idx_reg - IW'(1) == best_reg + IW'(1))
                        state_reg <= S_SPLIT;
                    else
                    begin
                        idx_reg <= idx_reg - IW'(1);
                        state_reg <= S_SHUP_RD;
                    end
                end
                // write new used entry then shrunk entry
                S_SPLIT:
                begin
                    if (pv_phase_reg)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                        state_reg <= S_RESP;
                    end
                    pv_phase_reg <= 1'b1;
                end
                S_FREE_NX: state_reg <= S_FREE_NXCHK;
                S_FREE_NXCHK:
                begin
                    // writes the target as free (merged when next is free)
                    if (!pv_phase_reg && !r_used)
                    begin
                        cur_sz_reg <= merged;
                        rmv_reg <= tgt_reg + IW'(1);
                        idx_reg <= tgt_reg + IW'(1);
                        state_reg <= S_SHDN_RD;
                    end
                    else
                        state_reg <= (tgt_reg != '0) ? S_FREE_PV : S_RESP;
                    pv_phase_reg <= 1'b1;
                end
                S_FREE_PV: state_reg <= S_FREE_PVCHK;
                S_FREE_PVCHK:
                begin
                    // previous entry is written only when it is free
                    if (!r_used)
                    begin
                        idx_reg <= tgt_reg;
                        rmv_reg <= tgt_reg;
                        pv_phase_reg <= 1'b0;
                        state_reg <= S_SHDN_RD;
                    end
                    else
                        state_reg <= S_RESP;
                end
                // move entries down over the removed one
                S_SHDN_RD:
                begin
                    if (CW'(idx_reg) + CW'(1) >= cnt_reg)
                    begin
                        cnt_reg <= cnt_reg - CW'(1);
                        if (rmv_reg != tgt_reg && tgt_reg != '0)
                            state_reg <= S_FREE_PV;
                        else
                            state_reg <= S_RESP;
                    end
                    else
                        state_reg <= S_SHDN_WR;
                end
                S_SHDN_WR:
                begin
                    idx_reg <= idx_reg + IW'(1);
                    state_reg <= S_SHDN_RD;
                end
                S_RESP:
                begin
                    if (rsp.ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign req.ready = (state_reg == S_IDLE) && !init_reg;
    assign rsp.valid = (state_reg == S_RESP);
    assign rsp.alloc_offset = (status_reg == ST_OK) ? out_off_reg : '0;
    assign rsp.status = status_reg;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != '0 && cnt_reg <= MAXC)
        else $error("segment count out of range");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("ready while response pending");
    a_free_off: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && func_reg == FUNC_FREE |-> rsp.alloc_offset == '0)
        else $error("free returned an offset");
endmodule

// ===== verif/bfha_tb_if.sv =====
`timescale 1ns / 1ps
// Clock tap for the monitor, which samples the channels at the rising edge.
interface bfha_tb_clk_if (input logic clk);
    logic tick;
    assign tick = clk;
endinterface

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import bfha_pkg::*;

    localparam int ARENA    = 4096;
    localparam int HDR      = 16;
    localparam int MAX_SEGS = 32;
    localparam int HOLD_LEN = 400;

    typedef struct packed {
        logic        func;
        logic [11:0] req_size;
        logic [11:0] data_offset;
    } alloc_req_t;

    typedef struct packed {
        logic [11:0] alloc_offset;
        status_t     status;
    } alloc_rsp_t;

    logic clk;
    logic rst_n;

    bfha_req_if    req ();
    bfha_rsp_if    rsp ();
    bfha_tb_clk_if clk_mon (.clk(clk));

    best_fit_heap_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Shadow segment table
    int unsigned seg_off [MAX_SEGS] = '{default: 0};
    int unsigned seg_sz  [MAX_SEGS] = '{0: ARENA - HDR, default: 0};
    bit          seg_busy[MAX_SEGS] = '{default: 0};
    int unsigned seg_cnt = 1;

    alloc_req_t  pending_reqs[$];
    alloc_rsp_t  expected_rsps[$];
    logic [11:0] live_offsets[$];

    int errors = 0;
    int sender_idle_pct;
    int receiver_idle_pct;
    int hold_req = 0;
    int hold_seen;
    int hold_cnt;
    int n_ok = 0, n_nofit = 0, n_full = 0, n_unknown = 0;
    int n_sent = 0;
    bit req_accepted;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drop entry idx and close the gap
    function automatic void drop_seg(input int unsigned idx);
        int unsigned k;
        for (k = idx; k + 1 < seg_cnt; k++)
        begin
            seg_off[k]  = seg_off[k + 1];
            seg_sz[k]   = seg_sz[k + 1];
            seg_busy[k] = seg_busy[k + 1];
        end
        seg_cnt--;
    endfunction

    // Compute the response of one request and update the shadow table
    function automatic alloc_rsp_t heap_step(input alloc_req_t r);
        alloc_rsp_t  o;
        int unsigned need, best_sz, best, k, pos, i;
        bit          found;
        o.alloc_offset = '0;
        o.status = ST_OK;
        found = 0;
        best = 0;
        if (r.func == FUNC_ALLOC)
        begin
            need = r.req_size + HDR;
            best_sz = ARENA + 1;
            for (i = 0; i < seg_cnt; i++)
            begin
                if (!seg_busy[i] && seg_sz[i] >= need && seg_sz[i] <= best_sz)
                begin
                    best = i;
                    best_sz = seg_sz[i];
                    found = 1;
                end
            end
            if (!found)
                o.status = ST_NO_FIT;
            else if (seg_cnt >= MAX_SEGS)
                o.status = ST_FULL;
            else
            begin
                seg_sz[best] -= need;
                pos = seg_off[best] + HDR + seg_sz[best];
                for (k = seg_cnt; k > best + 1; k--)
                begin
                    seg_off[k]  = seg_off[k - 1];
                    seg_sz[k]   = seg_sz[k - 1];
                    seg_busy[k] = seg_busy[k - 1];
                end
                seg_off[best + 1]  = pos;
                seg_sz[best + 1]   = r.req_size;
                seg_busy[best + 1] = 1;
                seg_cnt++;
                o.alloc_offset = 12'((pos + HDR) & 'hFFF);
            end
        end
        else if (r.data_offset != 0)
        begin
            for (i = 0; i < seg_cnt; i++)
            begin
                if (seg_off[i] + HDR == r.data_offset)
                begin
                    found = 1;
                    break;
                end
            end
            if (!found)
                o.status = ST_UNKNOWN;
            else
            begin
                seg_busy[i] = 0;
                if (i + 1 < seg_cnt && !seg_busy[i + 1])
                begin
                    seg_sz[i] += seg_sz[i + 1] + HDR;
                    drop_seg(i + 1);
                end
                if (i > 0 && !seg_busy[i - 1])
                begin
                    seg_sz[i - 1] += seg_sz[i] + HDR;
                    drop_seg(i);
                end
            end
        end
        return o;
    endfunction

    // Driver: one request offered at a time, changes at falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid       <= 1'b0;
            req.func        <= FUNC_ALLOC;
            req.req_size    <= '0;
            req.data_offset <= '0;
        end
        else
        begin
            if (req.valid && !req_accepted)
                ; // hold the current request
            else if (pending_reqs.size() != 0
                     && $urandom_range(99) >= sender_idle_pct)
            begin
                alloc_req_t r;
                r = pending_reqs.pop_front();
                req.valid       <= 1'b1;
                req.func        <= r.func;
                req.req_size    <= r.req_size;
                req.data_offset <= r.data_offset;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // Receiver ready, with random stalls and long hold-offs
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            hold_seen <= 0;
            hold_cnt  <= 0;
        end
        else if (hold_seen != hold_req)
        begin
            rsp.ready <= 1'b0;
            hold_seen <= hold_req;
            hold_cnt  <= HOLD_LEN - 1;
        end
        else if (hold_cnt > 0)
        begin
            rsp.ready <= 1'b0;
            hold_cnt  <= hold_cnt - 1;
        end
        else
            rsp.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Monitor: predict on accepted request, check on accepted response
    always @(posedge clk_mon.tick)
    begin
        req_accepted <= rst_n && req.valid && req.ready;
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                alloc_req_t r;
                alloc_rsp_t e;
                r.func = req.func;
                r.req_size = req.req_size;
                r.data_offset = req.data_offset;
                e = heap_step(r);
                expected_rsps.push_back(e);
                n_sent++;
                if (r.func == FUNC_ALLOC && e.status == ST_OK)
                    live_offsets.push_back(e.alloc_offset);
            end
            if (rsp.valid && rsp.ready)
            begin
                alloc_rsp_t e;
                if (expected_rsps.size() == 0)
                begin
                    $error("response with nothing expected: offset %0d status %0d",
                           rsp.alloc_offset, rsp.status);
                    errors++;
                end
                else
                begin
                    e = expected_rsps.pop_front();
                    if (rsp.alloc_offset !== e.alloc_offset)
                    begin
                        $error("alloc_offset expected %0d actual %0d",
                               e.alloc_offset, rsp.alloc_offset);
                        errors++;
                    end
                    if (rsp.status !== e.status)
                    begin
                        $error("status expected %0d actual %0d", e.status, rsp.status);
                        errors++;
                    end
                    case (e.status)
                        ST_OK:      n_ok++;
                        ST_NO_FIT:  n_nofit++;
                        ST_FULL:    n_full++;
                        default:    n_unknown++;
                    endcase
                end
            end
        end
    end

    function automatic alloc_req_t mk_alloc(input int unsigned sz);
        alloc_req_t r;
        r.func = FUNC_ALLOC;
        r.req_size = 12'(sz);
        r.data_offset = 12'($urandom);
        return r;
    endfunction

    function automatic alloc_req_t mk_free(input int unsigned off);
        alloc_req_t r;
        r.func = FUNC_FREE;
        r.req_size = 12'($urandom);
        r.data_offset = 12'(off);
        return r;
    endfunction

    // Wait until the queue is drained and all responses are back
    task automatic drain();
        while (pending_reqs.size() != 0 || req.valid || expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    // Random mix: mostly allocates and frees of live blocks, some noise
    task automatic random_batch(input int n);
        int i, sel, idx;
        for (i = 0; i < n; i++)
        begin
            // Keep prediction of live offsets current before choosing frees
            while (pending_reqs.size() > 2)
                @(posedge clk);
            sel = $urandom_range(99);
            if (sel < 45)
            begin
                if ($urandom_range(9) == 0)
                    pending_reqs.push_back(mk_alloc($urandom_range(4095)));
                else if ($urandom_range(3) == 0)
                    pending_reqs.push_back(mk_alloc($urandom_range(16)));
                else
                    pending_reqs.push_back(mk_alloc($urandom_range(300)));
            end
            else if (sel < 88 && live_offsets.size() != 0)
            begin
                idx = $urandom_range(live_offsets.size() - 1);
                pending_reqs.push_back(mk_free(live_offsets[idx]));
                live_offsets.delete(idx);
            end
            else if (sel < 94)
                pending_reqs.push_back(mk_free($urandom_range(4095)));
            else
                pending_reqs.push_back(mk_free(0));
        end
    endtask

    initial begin
        int i;
        sender_idle_pct = 38;
        receiver_idle_pct = 55;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: edges, zero size, null and unknown frees, exhaustion
        pending_reqs.push_back(mk_alloc(0));
        pending_reqs.push_back(mk_alloc(4095));
        pending_reqs.push_back(mk_free(0));
        pending_reqs.push_back(mk_free(4095));
        pending_reqs.push_back(mk_free(12'hAAA));
        pending_reqs.push_back(mk_free(12'h555));
        pending_reqs.push_back(mk_alloc(ARENA - 3 * HDR - 1)); // leaves one byte
        pending_reqs.push_back(mk_alloc(0));                    // nothing left
        pending_reqs.push_back(mk_free(ARENA - HDR - 0 - HDR)); // offset below the top
        pending_reqs.push_back(mk_free(HDR + 0));               // near-empty head
        drain();
        for (i = 0; i < live_offsets.size(); i++)
            pending_reqs.push_back(mk_free(live_offsets[i]));
        live_offsets.delete();
        // Fill the table to overflow with small allocations
        for (i = 0; i < 33; i++)
            pending_reqs.push_back(mk_alloc(i[0] ? 12'hFFF & 8 : 0));
        drain();
        // Free the same block twice
        if (live_offsets.size() > 2)
        begin
            pending_reqs.push_back(mk_free(live_offsets[1]));
            pending_reqs.push_back(mk_free(live_offsets[1]));
            live_offsets.delete(1);
        end
        drain();

        // Long receiver hold-off while the sender keeps offering
        hold_req++;
        sender_idle_pct = 0;
        for (i = 0; i < 6; i++)
            pending_reqs.push_back(mk_alloc($urandom_range(64)));
        drain();

        sender_idle_pct = 38;
        receiver_idle_pct = 55;
        random_batch(450);
        drain();   // sender pauses until every response is in
        sender_idle_pct = 55;
        receiver_idle_pct = 38;
        random_batch(450);
        drain();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        random_batch(450);
        drain();
        repeat (300) @(posedge clk);

        $display("testbench: %0d requests; ok %0d, no-fit %0d, full %0d, unknown %0d",
                 n_sent, n_ok, n_nofit, n_full, n_unknown);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("testbench: FAIL");
        $finish;
    end
endmodule
